// File: rtl/qtt_pkg.sv
// Shared types and character constants for the quoted text tokenizer.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package qtt_pkg;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // One result: token byte, byte-valid flag, token-end and last-of-run marks
    typedef struct packed {
        logic       run_last;
        logic       token_done;
        logic       char_valid;
        logic [7:0] token_char;
    } qtt_rec_t;

    // Everything one input item causes: one or two results
    typedef struct packed {
        logic     pair;
        qtt_rec_t rec1;
        qtt_rec_t rec0;
    } qtt_entry_t;

endpackage

`default_nettype wire

// File: rtl/quoted_text_tokenizer.sv
// Top level of the quoted text tokenizer: front end, result queue, back end.
// Depends on qtt_pkg, qtt_front, qtt_fifo and qtt_back.
`default_nettype none

// The block takes one text byte per cycle on the s_axis side and produces a
// stream of token results on the m_axis side. Bytes at or below space split
// bare tokens; a token opened by a single or double quote runs to the matching
// quote or a zero byte, neither of which is emitted, and may be empty; a "//"
// at a token start skips to the next newline. Each byte yields zero, one or
// two results, each holding one token byte or none, a token-end mark and a
// last-of-run mark (tlast). A byte with s_axis_tlast set closes any open
// token and returns the scanner to its reset state. Rate: one input item is
// accepted every cycle while the result queue (QUEUE_DEPTH entries) has room;
// the output stage sends one result per cycle while m_axis_tready is high, so
// a byte that yields two results (a held slash followed by a token byte) is
// sent as two results in turn and the queue absorbs such bursts. An accepted
// byte's first result passes through the queue write, then the output
// register. No clearing pass follows reset.
module quoted_text_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire         s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] token_char, [8] token_done, [15:9] zero
    output logic        m_axis_tuser,   // char_valid
    output logic        m_axis_tlast    // run_last
);
    import qtt_pkg::*;

    qtt_entry_t push_entry, head;
    qtt_rec_t   out_rec;
    logic       push, pop, full, empty;

    // classify bytes, hold scan state
    qtt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .text_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .q_full     (full),
        .q_push     (push),
        .q_entry    (push_entry)
    );

    // decouple the two sides
    qtt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // serialise entries into single results
    qtt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (empty),
        .q_pop   (pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_rec   (out_rec)
    );

    // pack the result item onto the stream ports
    assign m_axis_tdata = {7'b0, out_rec.token_done, out_rec.token_char};
    assign m_axis_tuser = out_rec.char_valid;
    assign m_axis_tlast = out_rec.run_last;

endmodule

`default_nettype wire

// File: rtl/qtt_front.sv
// Front end of the tokenizer: accepts text bytes, tracks the scan state and
// builds the results of each byte. Depends on qtt_pkg.
`default_nettype none

module qtt_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [7:0]          text_byte,
    input  wire                 final_byte,
    input  wire                 q_full,
    output logic                q_push,
    output qtt_pkg::qtt_entry_t q_entry
);
    import qtt_pkg::*;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_BARE    = 5'b01000,
        MODE_QUOTED  = 5'b10000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       quote_reg, quote_next;
    logic [1:0] n;
    qtt_rec_t   r0, r1;
    logic       is_sep, is_quote;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_sep  = (text_byte <= CHAR_SPACE);
    assign is_quote = quote_reg ? (text_byte == CHAR_SQUOTE) : (text_byte == CHAR_DQUOTE);

    always_comb begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        n  = 2'd0;
        r0 = '0;
        r1 = '0;
        case (mode_reg)
            MODE_SLASH: begin
                if (text_byte == CHAR_SLASH) begin
                    mode_next = MODE_COMMENT;
                end else if (is_sep) begin
                    r0 = '{run_last: 1'b0, token_done: 1'b1, char_valid: 1'b1,
                           token_char: CHAR_SLASH};
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                end else begin
                    r0 = '{run_last: 1'b0, token_done: 1'b0, char_valid: 1'b1,
                           token_char: CHAR_SLASH};
                    r1 = '{run_last: 1'b0, token_done: 1'b0, char_valid: 1'b1,
                           token_char: text_byte};
                    n = 2'd2;
                    mode_next = MODE_BARE;
                end
            end
            MODE_COMMENT: begin
                if (text_byte == CHAR_NL) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BARE: begin
                if (is_sep) begin
                    r0 = '{run_last: 1'b0, token_done: 1'b1, char_valid: 1'b0,
                           token_char: CHAR_NUL};
                    mode_next = MODE_IDLE;
                end else begin
                    r0 = '{run_last: 1'b0, token_done: 1'b0, char_valid: 1'b1,
                           token_char: text_byte};
                end
                n = 2'd1;
            end
            MODE_QUOTED: begin
                if (is_quote || text_byte == CHAR_NUL) begin
                    r0 = '{run_last: 1'b0, token_done: 1'b1, char_valid: 1'b0,
                           token_char: CHAR_NUL};
                    mode_next = MODE_IDLE;
                end else begin
                    r0 = '{run_last: 1'b0, token_done: 1'b0, char_valid: 1'b1,
                           token_char: text_byte};
                end
                n = 2'd1;
            end
            default: begin
                // between tokens, and any stray code
                mode_next = MODE_IDLE;
                if (is_sep) begin
                    mode_next = MODE_IDLE;
                end else if (text_byte == CHAR_SLASH) begin
                    mode_next = MODE_SLASH;
                end else if (text_byte == CHAR_DQUOTE || text_byte == CHAR_SQUOTE) begin
                    quote_next = (text_byte == CHAR_SQUOTE);
                    mode_next  = MODE_QUOTED;
                end else begin
                    r0 = '{run_last: 1'b0, token_done: 1'b0, char_valid: 1'b1,
                           token_char: text_byte};
                    n = 2'd1;
                    mode_next = MODE_BARE;
                end
            end
        endcase

        // close whatever is open on the last byte of the text
        if (final_byte) begin
            if (mode_next == MODE_SLASH) begin
                r0 = '{run_last: 1'b0, token_done: 1'b1, char_valid: 1'b1,
                       token_char: CHAR_SLASH};
                n = 2'd1;
            end else if (mode_next == MODE_BARE || mode_next == MODE_QUOTED) begin
                if (n == 2'd2) begin
                    r1.token_done = 1'b1;
                end else if (n == 2'd1) begin
                    r0.token_done = 1'b1;
                end else begin
                    r0 = '{run_last: 1'b0, token_done: 1'b1, char_valid: 1'b0,
                           token_char: CHAR_NUL};
                    n = 2'd1;
                end
            end
            mode_next  = MODE_IDLE;
            quote_next = 1'b0;
        end

        if (n == 2'd2) begin
            r1.run_last = 1'b1;
        end else begin
            r0.run_last = 1'b1;
        end
    end

    assign q_push  = accept && (n != 2'd0);
    assign q_entry = '{pair: (n == 2'd2), rec1: r1, rec0: r0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qtt_fifo.sv
// Short queue of result entries between the front and back ends.
// Depends on qtt_pkg for the entry type.
`default_nettype none

module qtt_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  qtt_pkg::qtt_entry_t push_entry,
    input  wire                 pop,
    output qtt_pkg::qtt_entry_t head,
    output logic                full,
    output logic                empty
);
    import qtt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qtt_entry_t      mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // front end never writes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("qtt_fifo: push while full");

    // back end never reads an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("qtt_fifo: pop while empty");

    // fill level tracks pushes and pops
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + CW'($past(push)) - CW'($past(pop)))
        else $error("qtt_fifo: fill count out of step");

endmodule

`default_nettype wire

// File: rtl/qtt_back.sv
// Back end of the tokenizer: drains queue entries and sends their one or
// two results out through a registered output stage. Depends on qtt_pkg.
`default_nettype none

module qtt_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  qtt_pkg::qtt_entry_t head,
    input  wire                 q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output qtt_pkg::qtt_rec_t   m_rec
);
    import qtt_pkg::*;

    logic     idx_reg, idx_next;
    logic     valid_reg, valid_next;
    qtt_rec_t rec_reg, rec_next;
    logic     load;

    assign load = (!valid_reg || m_ready) && !q_empty;

    always_comb begin
        idx_next   = idx_reg;
        rec_next   = rec_reg;
        valid_next = valid_reg && !m_ready;
        q_pop      = 1'b0;
        if (load) begin
            rec_next   = idx_reg ? head.rec1 : head.rec0;
            valid_next = 1'b1;
            if (idx_reg || !head.pair) begin
                q_pop    = 1'b1;
                idx_next = 1'b0;
            end else begin
                idx_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_rec   = rec_reg;

endmodule

`default_nettype wire
